### hdl/arpd_pkg.sv
package arpd_pkg;

    localparam int unsigned SAMPLE_W = 10;
    localparam int unsigned LEVEL_W  = 8;
    localparam int unsigned COUNT_W  = 10;
    localparam int unsigned CFG_W    = 10;
    localparam int unsigned INDEX_W  = 2;

    typedef enum logic [1:0] {
        CMD_STEP = 2'd0,
        CMD_ZERO = 2'd1,
        CMD_TICK = 2'd2
    } cmd_t;

    localparam logic [INDEX_W-1:0] REG_LOUD_THRESHOLD = 2'd0;
    localparam logic [INDEX_W-1:0] REG_HOLD_STEPS     = 2'd1;
    localparam logic [INDEX_W-1:0] REG_LEVEL_MAX      = 2'd2;

    localparam logic [SAMPLE_W-1:0] LOUD_THRESHOLD_RST = 10'd480;
    localparam logic [COUNT_W-1:0]  HOLD_STEPS_RST     = 10'd50;
    localparam logic [LEVEL_W-1:0]  LEVEL_MAX_RST      = 8'd100;

    localparam logic [LEVEL_W-1:0]  LEVEL_RST      = 8'd1;
    localparam logic [LEVEL_W-1:0]  DELAY_RST      = 8'd1;
    localparam logic [COUNT_W-1:0]  HOLD_COUNT_RST = 10'd990;
    localparam logic [COUNT_W-1:0]  COUNT_LIMIT    = 10'd1000;
    localparam logic [COUNT_W-1:0]  HOLD_WRAP      = 10'd990;
    localparam logic [LEVEL_W-1:0]  LEVEL_FLOOR    = 8'd3;
    localparam logic [LEVEL_W-1:0]  LEVEL_DROP     = 8'd2;
    localparam logic [LEVEL_W-1:0]  TICK_MAX       = 8'd255;

endpackage

### hdl/audio_reactive_phase_dimmer.sv
// A result is presented in the cycle after its request is accepted.
// Throughput: one request per cycle while no result is stalled, one state update per request.
// A request is taken whenever the result register is empty or is being taken in that cycle.
// Reset (asynchronous, active low) loads the default configuration and dimmer state,
// and empties the result register.
module audio_reactive_phase_dimmer
    import arpd_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                cfg_write,
    input  logic [INDEX_W-1:0]  cfg_index,
    input  logic [CFG_W-1:0]    cfg_data,
    input  logic                in_valid,
    output logic                in_stall,
    input  logic [1:0]          command,
    input  logic [SAMPLE_W-1:0] aux_sample,
    output logic                out_valid,
    input  logic                out_stall,
    output logic                gate_on,
    output logic                activity_led,
    output logic [LEVEL_W-1:0]  level,
    output logic [LEVEL_W-1:0]  phase_delay
);

    logic [SAMPLE_W-1:0] loud_threshold_reg;
    logic [COUNT_W-1:0]  hold_steps_reg;
    logic [LEVEL_W-1:0]  level_max_reg;

    logic [LEVEL_W-1:0]  dim_level_reg, dim_level_next;
    logic [LEVEL_W-1:0]  latched_delay_reg, latched_delay_next;
    logic [LEVEL_W-1:0]  tick_count_reg, tick_count_next;
    logic [COUNT_W-1:0]  step_count_reg, step_count_next;
    logic [COUNT_W-1:0]  hold_count_reg, hold_count_next;
    logic                gate_state_reg, gate_state_next;
    logic                led_state_reg, led_state_next;
    logic                out_valid_reg, out_valid_next;

    logic                accept;
    logic [COUNT_W-1:0]  hold_eff;
    logic [COUNT_W-1:0]  hold_inc;
    logic                hold_active;
    logic [LEVEL_W:0]    level_up;

    // The state registers double as the result payload; they only move on an accepted request.
    assign in_stall = out_valid_reg && out_stall;
    assign accept   = in_valid && !in_stall;

    assign hold_eff    = (aux_sample > loud_threshold_reg) ? '0 : hold_count_reg;
    assign hold_active = hold_eff < hold_steps_reg;
    assign hold_inc    = hold_eff + 1'b1;
    assign level_up    = {1'b0, dim_level_reg} + 1'b1;

    always_comb
    begin
        dim_level_next     = dim_level_reg;
        latched_delay_next = latched_delay_reg;
        tick_count_next    = tick_count_reg;
        step_count_next    = step_count_reg;
        hold_count_next    = hold_count_reg;
        gate_state_next    = gate_state_reg;
        led_state_next     = led_state_reg;
        out_valid_next     = out_valid_reg && out_stall;
        if (accept)
        begin
            out_valid_next = 1'b1;
            case (cmd_t'(command))
                CMD_STEP:
                begin
                    led_state_next = hold_active;
                    if (hold_active)
                    begin
                        if (dim_level_reg > LEVEL_FLOOR)
                        begin
                            dim_level_next = dim_level_reg - LEVEL_DROP;
                        end
                    end
                    else if (step_count_reg[1:0] == 2'b00)
                    begin
                        if (level_up > {1'b0, level_max_reg})
                        begin
                            dim_level_next = level_max_reg;
                        end
                        else
                        begin
                            dim_level_next = level_up[LEVEL_W-1:0];
                        end
                    end
                    step_count_next = (step_count_reg >= COUNT_LIMIT) ? '0
                                                                       : step_count_reg + 1'b1;
                    hold_count_next = (hold_inc > COUNT_LIMIT) ? HOLD_WRAP : hold_inc;
                end
                CMD_ZERO:
                begin
                    latched_delay_next = dim_level_reg;
                    tick_count_next    = '0;
                    gate_state_next    = 1'b0;
                end
                CMD_TICK:
                begin
                    if (tick_count_reg == latched_delay_reg)
                    begin
                        gate_state_next = 1'b1;
                    end
                    if (tick_count_reg != TICK_MAX)
                    begin
                        tick_count_next = tick_count_reg + 1'b1;
                    end
                end
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            loud_threshold_reg <= LOUD_THRESHOLD_RST;
            hold_steps_reg     <= HOLD_STEPS_RST;
            level_max_reg      <= LEVEL_MAX_RST;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                REG_LOUD_THRESHOLD: loud_threshold_reg <= cfg_data;
                REG_HOLD_STEPS:     hold_steps_reg     <= cfg_data;
                REG_LEVEL_MAX:      level_max_reg      <= cfg_data[LEVEL_W-1:0];
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dim_level_reg     <= LEVEL_RST;
            latched_delay_reg <= DELAY_RST;
            tick_count_reg    <= '0;
            step_count_reg    <= '0;
            hold_count_reg    <= HOLD_COUNT_RST;
            gate_state_reg    <= 1'b1;
            led_state_reg     <= 1'b1;
            out_valid_reg     <= 1'b0;
        end
        else
        begin
            dim_level_reg     <= dim_level_next;
            latched_delay_reg <= latched_delay_next;
            tick_count_reg    <= tick_count_next;
            step_count_reg    <= step_count_next;
            hold_count_reg    <= hold_count_next;
            gate_state_reg    <= gate_state_next;
            led_state_reg     <= led_state_next;
            out_valid_reg     <= out_valid_next;
        end
    end

    assign out_valid    = out_valid_reg;
    assign gate_on      = gate_state_reg;
    assign activity_led = led_state_reg;
    assign level        = dim_level_reg;
    assign phase_delay  = latched_delay_reg;

endmodule

### hdl/arpd_checker.sv
module arpd_checker
    import arpd_pkg::*;
(
    input logic                clk,
    input logic                rst_n,
    input logic                in_valid,
    input logic                in_stall,
    input logic [1:0]          command,
    input logic                out_valid,
    input logic                out_stall,
    input logic                gate_on,
    input logic                activity_led,
    input logic [LEVEL_W-1:0]  level,
    input logic [LEVEL_W-1:0]  phase_delay
);

    // A stalled result must hold its value until it is taken.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(level) && $stable(phase_delay)
            && $stable(gate_on) && $stable(activity_led))
        else $error("stalled result changed");

    // Every accepted request shows up as a result in the next cycle.
    assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall |=> out_valid)
        else $error("accepted request produced no result");

    // A zero crossing turns the gate off and latches the current level.
    assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall && command == CMD_ZERO |=>
            !gate_on && phase_delay == level)
        else $error("zero crossing result wrong");

    // A tick leaves level, delay and activity indication alone.
    assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall && command == CMD_TICK |=>
            $stable(level) && $stable(phase_delay) && $stable(activity_led))
        else $error("tick changed level state");

    // Once fired, the gate stays on until a zero crossing.
    assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall && command != CMD_ZERO && gate_on |=> gate_on)
        else $error("gate dropped without zero crossing");

endmodule

bind audio_reactive_phase_dimmer arpd_checker u_arpd_checker (.*);

### sim/audio_reactive_phase_dimmer_tb.sv
`timescale 1ns / 1ps

module audio_reactive_phase_dimmer_tb;
    import arpd_pkg::*;

    localparam logic [1:0] CMD_UNUSED = 2'd3;

    typedef struct packed {
        logic [1:0]          cmd;
        logic [SAMPLE_W-1:0] sample;
    } request_t;

    typedef struct packed {
        logic               gate;
        logic               led;
        logic [LEVEL_W-1:0] level;
        logic [LEVEL_W-1:0] delay;
    } dimmer_out_t;

    logic                clk = 1'b0;
    logic                rst_n = 1'b0;
    logic                cfg_write = 1'b0;
    logic [INDEX_W-1:0]  cfg_index = '0;
    logic [CFG_W-1:0]    cfg_data = '0;
    logic                in_valid = 1'b0;
    logic                in_stall;
    logic [1:0]          command = '0;
    logic [SAMPLE_W-1:0] aux_sample = '0;
    logic                out_valid;
    logic                out_stall = 1'b0;
    logic                gate_on;
    logic                activity_led;
    logic [LEVEL_W-1:0]  level;
    logic [LEVEL_W-1:0]  phase_delay;

    request_t    pending_requests[$];
    dimmer_out_t expected_results[$];
    int          requests_queued = 0;
    int          requests_taken = 0;
    int          mismatches = 0;
    int          send_idle_pct = 0;
    int          stall_pct = 0;
    logic        req_taken = 1'b0;

    // Shadow copy of the dimmer configuration and state.
    logic [SAMPLE_W-1:0] m_thr;
    logic [COUNT_W-1:0]  m_hold_steps;
    logic [LEVEL_W-1:0]  m_level_max;
    logic [LEVEL_W-1:0]  m_level;
    logic [LEVEL_W-1:0]  m_delay;
    logic [LEVEL_W-1:0]  m_tick;
    logic [COUNT_W-1:0]  m_step;
    logic [COUNT_W-1:0]  m_hold;
    logic                m_gate;
    logic                m_led;

    audio_reactive_phase_dimmer DUT (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_write    (cfg_write),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .command      (command),
        .aux_sample   (aux_sample),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .gate_on      (gate_on),
        .activity_led (activity_led),
        .level        (level),
        .phase_delay  (phase_delay)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    function automatic dimmer_out_t advance_dimmer(input logic [1:0] cmd,
                                                   input logic [SAMPLE_W-1:0] sample);
        logic [LEVEL_W:0] raised;
        dimmer_out_t      r;
        case (cmd)
            CMD_STEP:
            begin
                if (sample > m_thr)
                    m_hold = '0;
                if (m_hold < m_hold_steps)
                begin
                    m_led = 1'b1;
                    if (m_level > LEVEL_FLOOR)
                        m_level = m_level - LEVEL_DROP;
                end
                else
                begin
                    m_led = 1'b0;
                    // The level only rises on control steps whose step count is a multiple of four.
                    if (m_step[1:0] == 2'd0)
                    begin
                        raised = {1'b0, m_level} + 1'b1;
                        if (raised > {1'b0, m_level_max})
                            raised = {1'b0, m_level_max};
                        m_level = raised[LEVEL_W-1:0];
                    end
                end
                m_step = (m_step == COUNT_LIMIT) ? '0 : m_step + 1'b1;
                m_hold = (m_hold == COUNT_LIMIT) ? HOLD_WRAP : m_hold + 1'b1;
            end
            CMD_ZERO:
            begin
                m_delay = m_level;
                m_tick  = '0;
                m_gate  = 1'b0;
            end
            CMD_TICK:
            begin
                if (m_tick == m_delay)
                    m_gate = 1'b1;
                if (m_tick < TICK_MAX)
                    m_tick = m_tick + 1'b1;
            end
            default:
            begin
            end
        endcase
        r.gate  = m_gate;
        r.led   = m_led;
        r.level = m_level;
        r.delay = m_delay;
        return r;
    endfunction

    // Driver: presents requests at the falling edge and holds them until taken.
    always @(negedge clk)
    begin
        request_t next_req;
        logic     holding;
        holding = in_valid && !req_taken;
        if (!rst_n)
            in_valid <= 1'b0;
        else if (!holding)
        begin
            if (pending_requests.size() != 0 && $urandom_range(99) >= send_idle_pct)
            begin
                next_req = pending_requests.pop_front();
                command    <= next_req.cmd;
                aux_sample <= next_req.sample;
                in_valid   <= 1'b1;
            end
            else
                in_valid <= 1'b0;
        end
        out_stall <= rst_n && ($urandom_range(99) < stall_pct);
    end

    // Monitor: tracks configuration writes, predicts each taken request and checks results.
    always @(posedge clk)
    begin
        dimmer_out_t want;
        if (!rst_n)
        begin
            m_thr        = LOUD_THRESHOLD_RST;
            m_hold_steps = HOLD_STEPS_RST;
            m_level_max  = LEVEL_MAX_RST;
            m_level      = LEVEL_RST;
            m_delay      = DELAY_RST;
            m_tick       = '0;
            m_step       = '0;
            m_hold       = HOLD_COUNT_RST;
            m_gate       = 1'b1;
            m_led        = 1'b1;
            req_taken    = 1'b0;
        end
        else
        begin
            if (cfg_write)
            begin
                case (cfg_index)
                    REG_LOUD_THRESHOLD: m_thr = cfg_data[SAMPLE_W-1:0];
                    REG_HOLD_STEPS:     m_hold_steps = cfg_data[COUNT_W-1:0];
                    REG_LEVEL_MAX:      m_level_max = cfg_data[LEVEL_W-1:0];
                    default:            ;
                endcase
            end
            if (out_valid && !out_stall)
            begin
                if (expected_results.size() == 0)
                begin
                    $error("result with no request outstanding");
                    mismatches++;
                end
                else
                begin
                    want = expected_results.pop_front();
                    if (gate_on !== want.gate)
                    begin
                        $error("gate_on: expected %0d, got %0d", want.gate, gate_on);
                        mismatches++;
                    end
                    if (activity_led !== want.led)
                    begin
                        $error("activity_led: expected %0d, got %0d", want.led, activity_led);
                        mismatches++;
                    end
                    if (level !== want.level)
                    begin
                        $error("level: expected %0d, got %0d", want.level, level);
                        mismatches++;
                    end
                    if (phase_delay !== want.delay)
                    begin
                        $error("phase_delay: expected %0d, got %0d", want.delay, phase_delay);
                        mismatches++;
                    end
                end
            end
            req_taken = in_valid && !in_stall;
            if (req_taken)
            begin
                expected_results.push_back(advance_dimmer(command, aux_sample));
                requests_taken++;
            end
        end
    end

    task automatic queue_request(input logic [1:0] cmd, input logic [SAMPLE_W-1:0] sample);
        request_t r;
        r.cmd    = cmd;
        r.sample = sample;
        pending_requests.push_back(r);
        requests_queued++;
    endtask

    function automatic logic [SAMPLE_W-1:0] audio_sample(input logic [SAMPLE_W-1:0] thr);
        if (thr != 10'd1023 && $urandom_range(99) < 10)
            return SAMPLE_W'($urandom_range(1023, thr + 1));
        return SAMPLE_W'($urandom_range(thr, 0));
    endfunction

    task automatic wait_until_drained();
        while (requests_taken != requests_queued || expected_results.size() != 0)
            @(negedge clk);
        repeat (3) @(negedge clk);
    endtask

    task automatic write_register(input logic [INDEX_W-1:0] idx, input logic [CFG_W-1:0] data);
        @(negedge clk);
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(negedge clk);
        cfg_write <= 1'b0;
    endtask

    // One mains half cycle: a zero crossing, then ticks with control steps mixed in.
    // A few stray requests of any kind break up the sequence.
    task automatic queue_mains_cycle(input logic [SAMPLE_W-1:0] thr,
                                     input logic [LEVEL_W-1:0] lmax, input int step_pct,
                                     input int last);
        int ticks;
        queue_request(CMD_ZERO, SAMPLE_W'($urandom_range(1023)));
        if ($urandom_range(99) < 8)
            ticks = $urandom_range(300, 256);
        else
            ticks = $urandom_range(lmax + 6);
        for (int t = 0; t < ticks && requests_queued < last; t++)
        begin
            while ($urandom_range(99) < step_pct)
                queue_request(CMD_STEP, audio_sample(thr));
            if ($urandom_range(99) < 6)
                queue_request(2'($urandom_range(3)), SAMPLE_W'($urandom_range(1023)));
            queue_request(CMD_TICK, SAMPLE_W'($urandom_range(1023)));
        end
    endtask

    task automatic run_phase(input logic [SAMPLE_W-1:0] thr, input logic [COUNT_W-1:0] hold,
                             input logic [LEVEL_W-1:0] lmax, input bit write_cfg,
                             input int send_pct, input int recv_pct, input int step_pct,
                             input int n_items);
        int first;
        wait_until_drained();
        if (write_cfg)
        begin
            write_register(REG_LOUD_THRESHOLD, thr);
            write_register(REG_HOLD_STEPS, hold);
            write_register(REG_LEVEL_MAX, {{(CFG_W-LEVEL_W){1'b0}}, lmax});
        end
        send_idle_pct = send_pct;
        stall_pct     = recv_pct;
        first = requests_queued;
        while (requests_queued - first < n_items)
            queue_mains_cycle(thr, lmax, step_pct, first + n_items);
    endtask

    initial
    begin
        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Directed opening: unknown command, gate firing at the delay, threshold edges.
        queue_request(CMD_UNUSED, 10'd1023);
        queue_request(CMD_TICK, 10'd0);
        queue_request(CMD_ZERO, 10'd0);
        queue_request(CMD_TICK, 10'd0);
        queue_request(CMD_TICK, 10'd0);
        queue_request(CMD_STEP, 10'd0);
        queue_request(CMD_STEP, 10'd480);
        queue_request(CMD_STEP, 10'd481);
        queue_request(CMD_STEP, 10'd1023);
        queue_request(CMD_STEP, 10'h2AA);
        queue_request(CMD_STEP, 10'h155);
        repeat (4) queue_request(CMD_STEP, 10'd0);
        queue_request(CMD_UNUSED, 10'd0);
        queue_request(CMD_ZERO, 10'd1023);
        repeat (3) queue_request(CMD_TICK, 10'd1023);

        run_phase(LOUD_THRESHOLD_RST, HOLD_STEPS_RST, LEVEL_MAX_RST, 1'b0, 0, 0, 40, 200);
        // Never loud, no hold: the level climbs and the step counter is pushed toward its wrap.
        run_phase(10'd1023, 10'd0, 8'd4, 1'b1, 55, 0, 80, 230);
        run_phase(10'd0, 10'd1000, 8'd255, 1'b1, 0, 55, 30, 230);
        run_phase(10'd200, 10'd10, 8'd12, 1'b1, 11, 11, 60, 230);
        // A maximum below the present level and below four clamps on the next rise.
        run_phase(10'd1023, 10'd5, 8'd3, 1'b1, 0, 0, 50, 200);
        // A hold longer than the counter can reach never ends.
        run_phase(10'd600, 10'd1023, 8'd255, 1'b1, 55, 0, 40, 230);
        run_phase(SAMPLE_W'($urandom_range(1023)), COUNT_W'($urandom_range(1023)),
                  LEVEL_W'($urandom_range(255, 4)), 1'b1, 0, 55, 50, 230);

        wait_until_drained();
        repeat (5) @(negedge clk);
        if (mismatches == 0)
            $display("audio_reactive_phase_dimmer_tb passed");
        else
            $display("audio_reactive_phase_dimmer_tb failed");
        $finish;
    end

    initial
    begin
        #2_000_000;
        $display("audio_reactive_phase_dimmer_tb failed");
        $finish;
    end

endmodule

### audio_reactive_phase_dimmer.f
hdl/arpd_pkg.sv
hdl/audio_reactive_phase_dimmer.sv
hdl/arpd_checker.sv
sim/audio_reactive_phase_dimmer_tb.sv
